// File: rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the circular deque and its ring memory.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int unsigned DataWidth = 32;

   // operation codes
   localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_REAR   = 3'd3;
   localparam logic [2:0] OP_DUMP       = 3'd4;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic signed [DataWidth-1:0] word_type;

   typedef struct packed {
      logic [2:0] op;
      word_type   value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      word_type   data;
      logic       last;
      logic       now_full;
      logic       now_empty;
   } rsp_type;

endpackage

// File: rtl/core/cdq_ring.sv
// ----------------------------------------------------------------------------
// cdq_ring
// Ring storage of the deque: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cdq_ring #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  cdq_pkg::word_type          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output cdq_pkg::word_type          rd_data
);
   import cdq_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words held in a ring memory.
// ----------------------------------------------------------------------------
// Usage: drive req_item and raise start; the item is taken at the edge where
// start is high and busy is low. Results appear on rsp_item for one cycle,
// flagged by rsp_strobe; the receiver must take them as they come.
// Every result carries now_full/now_empty for the state after the operation.
// Timing by operation:
//   push (either end)   : result in the next cycle, next item at once.
//   pop (either end)    : word via ring read and result registers; busy in
//                         S_READ, and no new item is taken while busy.
//   dump of n words     : first word via ring read and result registers,
//                         then one word per cycle, last flagged, while busy.
//   refused push/pop, dump of an empty deque: one result in the next cycle.
//   codes five to seven : taken, no result.
// The single read port of the ring sets the pop and dump timing.
// Reset: head and tail return to entry 0 and the deque is empty; ring
// contents are not cleared and never read before being written.
// ----------------------------------------------------------------------------
module circular_deque #(
   parameter int unsigned DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cdq_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_strobe,
   output cdq_pkg::rsp_type rsp_item
);
   import cdq_pkg::*;

   localparam int unsigned IdxWidth = $clog2(DEPTH);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_DUMP = 3'b100
   } state_type;

   function automatic logic [IdxWidth-1:0] wrap_inc(input logic [IdxWidth-1:0] i);
      return (i == LastIdx) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IdxWidth-1:0] wrap_dec(input logic [IdxWidth-1:0] i);
      return (i == '0) ? LastIdx : i - 1'b1;
   endfunction

   state_type           state_ff, state_in;
   logic [IdxWidth-1:0] head_ff, head_in;
   logic [IdxWidth-1:0] tail_ff, tail_in;
   logic                empty_ff, empty_in;
   logic [IdxWidth-1:0] rd_idx_ff, rd_idx_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_item_ff;

   logic [1:0]          rsp_status_in;
   word_type            rsp_data_in;
   logic                rsp_last_in;

   logic                full_cur;
   logic                full_next;

   logic                wr_en;
   logic [IdxWidth-1:0] wr_addr;
   logic                rd_en;
   logic [IdxWidth-1:0] rd_addr;
   word_type            rd_data;

   cdq_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full_cur  = !empty_ff && (wrap_inc(tail_ff) == head_ff);
   assign full_next = !empty_in && (wrap_inc(tail_in) == head_in);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_item.op)
                  OP_PUSH_REAR, OP_PUSH_FRONT: begin
                     rsp_strobe_in = 1'b1;
                     if (full_cur) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (empty_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b0;
                           wr_addr  = '0;
                        end else if (req_item.op == OP_PUSH_REAR) begin
                           tail_in = wrap_inc(tail_ff);
                           wr_addr = wrap_inc(tail_ff);
                        end else begin
                           head_in = wrap_dec(head_ff);
                           wr_addr = wrap_dec(head_ff);
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_REAR: begin
                     if (empty_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = (req_item.op == OP_POP_FRONT) ? head_ff : tail_ff;
                        state_in = S_READ;
                        if (head_ff == tail_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else if (req_item.op == OP_POP_FRONT) begin
                           head_in = wrap_inc(head_ff);
                        end else begin
                           tail_in = wrap_dec(tail_ff);
                        end
                     end
                  end
                  OP_DUMP: begin
                     if (empty_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = head_ff;
                        rd_idx_in = head_ff;
                        state_in  = S_DUMP;
                     end
                  end
                  default: begin
                     // unused codes: item dropped
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rd_data;
            state_in      = S_IDLE;
         end
         S_DUMP: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rd_data;
            rsp_last_in   = (rd_idx_ff == tail_ff);
            if (rd_idx_ff == tail_ff) begin
               state_in = S_IDLE;
            end else begin
               // fetch the following entry while this one goes out
               rd_en     = 1'b1;
               rd_addr   = wrap_inc(rd_idx_ff);
               rd_idx_in = wrap_inc(rd_idx_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (rsp_strobe_in) begin
         rsp_item_ff.status    <= rsp_status_in;
         rsp_item_ff.data      <= rsp_data_in;
         rsp_item_ff.last      <= rsp_last_in;
         rsp_item_ff.now_full  <= full_next;
         rsp_item_ff.now_empty <= empty_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
